// ===== src/first_fit_heap_allocator_defines.svh =====
// Assertion helpers shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define FFHA_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define FFHA_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// ===== src/ffha_pkg.sv =====
package ffha_pkg;

    localparam int ADDR_W    = 22;
    localparam int OUTCOME_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUT_REUSED   = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_APPENDED = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_NO_ROOM  = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_ZERO     = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_FREED    = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_IGNORED  = 3'd5;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] req_size;
        logic [ADDR_W-1:0] address;
    } t_req_in;

    typedef struct packed {
        logic [ADDR_W-1:0]    alloc_address;
        logic [OUTCOME_W-1:0] outcome;
        logic [ADDR_W-1:0]    bytes_in_use;
    } t_res;

    // request as broadcast to every cell during a scan
    typedef struct packed {
        logic              en;
        logic              kind;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } t_bcast;

    // search front handed from cell to cell
    typedef struct packed {
        logic              live;
        logic              found;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
    } t_wave;

    // append write
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
    } t_wr;

endpackage

// ===== src/first_fit_heap_allocator.sv =====
// First-fit heap allocator, no block splitting.
// Request channel: drive i_req and pulse start while busy is low; the request
// is taken at that edge. kind 0 allocates req_size bytes, kind 1 frees the
// block whose data address is i_req.address.
// Result channel: o_strobe is high for one cycle with o_res (address given,
// outcome code, bytes in use). There is no back-pressure; the receiver must
// take the result in that cycle.
// The accepting edge registers the request and kick; the search front then
// passes each cell register, and strobe and o_res load as it leaves the last.
// A request is handled by a search front that walks the row of table cells,
// one cell per cycle, so every request costs the full row length. busy drops
// in the strobe cycle, so a new request can be taken at the edge ending it;
// requests are not overlapped.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
// (0 heap start, 1 heap limit, others ignored). Writing heap start empties
// the table, clears the byte count and moves the heap top. Write only while
// idle.
// Reset (synchronous, i_rst_n low): empty table, heap start and limit zero,
// byte count zero, nothing in flight.
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 8,
    parameter int PAD_BYTES    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req_in              i_req,
    output logic                 o_strobe,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = ADDR_W + 2;   // room for sums before saturation
    localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] PAD   = SW'(PAD_BYTES);
    localparam logic [SW-1:0] AMAX  = {2'b00, {ADDR_W{1'b1}}};

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state            r_state;
    logic              r_kick;
    t_bcast            r_bcast;
    logic [ADDR_W-1:0] r_start;
    logic [ADDR_W-1:0] r_limit;
    logic [ADDR_W-1:0] r_top;
    logic [ADDR_W-1:0] r_used;
    logic [CW-1:0]     r_count;
    logic              r_strobe;
    t_res              r_res;

    t_wave             w_wave [MAX_BLOCKS+1];
    t_wave             w_end;
    t_wr               w_wr;
    logic              w_accept;
    logic [SW-1:0]     w_end_sum;
    logic [SW-1:0]     w_top_sum;
    logic [SW-1:0]     w_add;
    logic [SW-1:0]     w_add_sum;
    logic [SW-1:0]     w_sub;
    logic              w_no_room;
    logic [ADDR_W-1:0] n_used;
    logic [ADDR_W-1:0] n_top;
    logic [ADDR_W-1:0] n_addr;
    logic [OUTCOME_W-1:0] n_outcome;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // ---- row of table cells; the search front enters at cell 0 ----
    assign w_wave[0] = '{live: r_kick, found: 1'b0, addr: '0, size: '0};

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffha_cell #(
            .IDX(g),
            .CW (CW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_bcast(r_bcast),
            .i_wr   (w_wr),
            .i_count(r_count),
            .i_wave (w_wave[g]),
            .o_wave (w_wave[g+1])
        );
    end

    assign w_end = w_wave[MAX_BLOCKS];

    // ---- finish: the front leaving the last cell carries the match ----
    assign w_end_sum = {2'b00, r_top} + {2'b00, r_bcast.size} + HDR;
    assign w_top_sum = w_end_sum + PAD;
    assign w_no_room = (w_end_sum >= {2'b00, r_limit}) || (r_count >= CW'(MAX_BLOCKS));
    assign w_sub     = {2'b00, w_end.size} + HDR;

    always_comb begin
        n_addr    = '0;
        n_outcome = OUT_IGNORED;
        n_top     = r_top;
        w_add     = '0;
        w_wr      = '0;
        n_used    = r_used;
        if (r_bcast.kind == KIND_FREE) begin
            if (w_end.found) begin
                n_outcome = OUT_FREED;
                n_used = (w_sub > {2'b00, r_used}) ? '0
                                                   : ADDR_W'({2'b00, r_used} - w_sub);
            end
        end else if (!r_bcast.en) begin
            n_outcome = OUT_ZERO;
        end else if (w_end.found) begin
            n_outcome = OUT_REUSED;
            n_addr    = w_end.addr;
            w_add     = {2'b00, r_bcast.size} + HDR;
        end else if (w_no_room) begin
            n_outcome = OUT_NO_ROOM;
        end else begin
            n_outcome = OUT_APPENDED;
            n_addr    = ADDR_W'({2'b00, r_top} + HDR);
            w_add     = {2'b00, r_bcast.size} + HDR + PAD;
            n_top     = (w_top_sum > AMAX) ? {ADDR_W{1'b1}} : ADDR_W'(w_top_sum);
            w_wr.en   = w_end.live;
            w_wr.addr = n_addr;
            w_wr.size = r_bcast.size;
        end
        w_add_sum = {2'b00, r_used} + w_add;
        if (r_bcast.kind == KIND_ALLOC) begin
            n_used = (w_add_sum > AMAX) ? {ADDR_W{1'b1}} : ADDR_W'(w_add_sum);
        end
    end

    // ---- control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kick   <= 1'b0;
            r_strobe <= 1'b0;
            r_start  <= '0;
            r_limit  <= '0;
            r_top    <= '0;
            r_used   <= '0;
            r_count  <= '0;
        end else begin
            r_kick   <= w_accept;
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_end.live) begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                        r_used   <= n_used;
                        r_top    <= n_top;
                        if (w_wr.en) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEAP_START: begin
                        r_start <= i_cfg_data;
                        r_top   <= i_cfg_data;
                        r_used  <= '0;
                        r_count <= '0;
                    end
                    CFG_HEAP_LIMIT: begin
                        r_limit <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // request hold and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bcast.kind <= i_req.kind;
            r_bcast.size <= i_req.req_size;
            r_bcast.addr <= i_req.address;
            if (i_req.kind == KIND_ALLOC) begin
                r_bcast.en <= (i_req.req_size != '0);
            end else begin
                r_bcast.en <= (i_req.address != '0);
            end
        end
        if (r_state == S_SCAN && w_end.live) begin
            r_res.alloc_address <= n_addr;
            r_res.outcome       <= n_outcome;
            r_res.bytes_in_use  <= n_used;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // the heap top only moves away from heap start on an append
    `FFHA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request accepted but not busy")
    `FFHA_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(MAX_BLOCKS), "table overrun")
    `FFHA_ASSERT_IMP(a_top_empty, r_count == '0, r_top == r_start, "top moved with empty table")
    `FFHA_ASSERT_IMP(a_strobe_scan, o_strobe, $past(r_state == S_SCAN), "stray result")
    `FFHA_ASSERT_IMP(a_front_scan, w_end.live, r_state == S_SCAN, "front outside scan")

endmodule

// ===== src/ffha_cell.sv =====
module ffha_cell
    import ffha_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_bcast        i_bcast,
    input  t_wr           i_wr,
    input  logic [CW-1:0] i_count,
    input  t_wave         i_wave,
    output t_wave         o_wave
);

    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_size;
    logic              r_used;
    t_wave             r_wave;
    t_wave             n_wave;
    logic              w_occ;
    logic              w_fit;
    logic              w_hit;
    logic              w_wr;

    assign w_occ = (CW'(IDX) < i_count);
    assign w_wr  = i_wr.en && (i_count == CW'(IDX));

    always_comb begin
        if (i_bcast.kind == KIND_ALLOC) begin
            w_fit = !r_used && (r_size >= i_bcast.size);
        end else begin
            w_fit = r_used && (r_addr == i_bcast.addr);
        end
    end

    assign w_hit = i_wave.live && !i_wave.found && i_bcast.en && w_occ && w_fit;

    always_comb begin
        n_wave = i_wave;
        if (w_hit) begin
            n_wave.found = 1'b1;
            n_wave.addr  = r_addr;
            n_wave.size  = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_wave <= '0;
        end else begin
            r_wave <= n_wave;
            if (w_wr) begin
                r_used <= 1'b1;
            end else if (w_hit) begin
                r_used <= (i_bcast.kind == KIND_ALLOC);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_addr <= i_wr.addr;
            r_size <= i_wr.size;
        end
    end

    assign o_wave = r_wave;

endmodule
